### rtl/brd_pkg.sv
// Package for the Bayer replication demosaic unit.
// Holds the word types, register indexes and the plane helper functions.
// No dependencies.
`timescale 1ns / 1ps

package brd_pkg;

   // Widths fixed by the register map and the word layout
   localparam int CFG_W   = 13;
   localparam int DEPTH_W = 5;
   localparam int ORDER_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int RAW_W   = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_DEPTH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOSAIC_ORDER = 2'd3;

   // Reset values of the registers
   localparam logic [CFG_W-1:0]   RESET_WIDTH  = 13'd4096;
   localparam logic [CFG_W-1:0]   RESET_HEIGHT = 13'd4096;
   localparam logic [DEPTH_W-1:0] RESET_DEPTH  = 5'd8;
   localparam logic [ORDER_W-1:0] RESET_ORDER  = 2'd0;

   // Depth at which no shift is needed
   localparam logic [DEPTH_W-1:0] BYTE_DEPTH = 5'd8;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] green_byte;
      logic [7:0] third_byte;
      logic       last_of_frame;
   } rsp_type;

   // Position flags of one pixel, passed from the counters to the plane logic
   typedef struct packed {
      logic x_odd;
      logic y_odd;
      logic x_zero;
      logic y_zero;
      logic last;
   } pos_type;

   // Value of a plane whose anchors sit at column parity pc and row parity pr.
   // An anchor left of column 0 or above row 0 was never written, so it reads 0.
   function automatic logic [RAW_W-1:0] anchor_value(
      input pos_type          pos,
      input logic             pc,
      input logic             pr,
      input logic [RAW_W-1:0] here,
      input logic [RAW_W-1:0] above,
      input logic [RAW_W-1:0] left,
      input logic [RAW_W-1:0] above_left
   );
      logic back_col;
      logic back_row;
      logic [RAW_W-1:0] result;
      back_col = pos.x_odd != pc;
      back_row = pos.y_odd != pr;
      if ((back_col && pos.x_zero) || (back_row && pos.y_zero)) begin
         result = '0;
      end else if (!back_row) begin
         result = back_col ? left : here;
      end else begin
         result = back_col ? above_left : above;
      end
      return result;
   endfunction

   // Scale a raw sample down to a byte: shift right by depth minus eight, or not at all for a depth of eight or less
   function automatic logic [7:0] to_byte(
      input logic [RAW_W-1:0]   value,
      input logic [DEPTH_W-1:0] depth
   );
      logic [DEPTH_W-1:0] shift;
      logic [RAW_W-1:0]   shifted;
      shift   = (depth > BYTE_DEPTH) ? depth - BYTE_DEPTH : '0;
      shifted = value >> shift;
      return shifted[7:0];
   endfunction

endpackage

### rtl/bayer_replication_demosaic_unit.sv
// Top level of the Bayer replication demosaic unit.
// Depends on brd_pkg, brd_position, brd_line_buffer and brd_plane_select.
//
//   Port group   Direction   Handshake            Word
//   req_         in          req_valid/req_stall  req_type: raw sample, frame start
//   rsp_         out         rsp_valid/rsp_stall  rsp_type: three bytes, last of frame
//   csr_         in          csr_valid/csr_ready  register index and write data
//
// One word is accepted per cycle while req_stall is low; each result passes the
// registered read of the line buffer and the result register. Reset is synchronous and
// clears counters, neighbour registers and valid flags; the line buffer holds no reset
// value; that it is only read after it has been written is left to the user. A stall on
// the result side backs up through the input stage to req_stall.
`timescale 1ns / 1ps

module bayer_replication_demosaic_unit #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  brd_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output brd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [brd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [brd_pkg::CFG_W-1:0]         csr_data
);
   import brd_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   // Configuration registers
   logic [CFG_W-1:0]   image_width_ff, image_height_ff;
   logic [DEPTH_W-1:0] bit_depth_ff;
   logic [ORDER_W-1:0] mosaic_order_ff;

   // Input stage and neighbour registers
   logic                  s1_valid_ff;
   pos_type               s1_pos_ff;
   logic [PIXEL_BITS-1:0] s1_here_ff, s1_left_ff;
   logic [PIXEL_BITS-1:0] left_pixel_ff, above_left_ff;

   // Result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic                  accept, advance;
   logic [PIXEL_BITS-1:0] here, above;
   logic [AW-1:0]         column;
   pos_type               pos;
   rsp_type               rsp_next;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RESET_WIDTH;
         image_height_ff <= RESET_HEIGHT;
         bit_depth_ff    <= RESET_DEPTH;
         mosaic_order_ff <= RESET_ORDER;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            CSR_BIT_DEPTH:    bit_depth_ff    <= csr_data[DEPTH_W-1:0];
            CSR_MOSAIC_ORDER: mosaic_order_ff <= csr_data[ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the input stage moves on when the result register is free or emptying
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign here = req_data.raw_pixel[PIXEL_BITS-1:0];

   brd_position #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .frame_start  (req_data.frame_start),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .column       (column),
      .pos          (pos)
   );

   brd_line_buffer #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_BITS)
   ) u_line_buffer (
      .clock   (clock),
      .access  (accept),
      .addr    (column),
      .wr_data (here),
      .rd_data (above)
   );

   // Input stage: holds the word while its row-above sample is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         left_pixel_ff <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff   <= 1'b1;
            left_pixel_ff <= here;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff  <= pos;
         s1_here_ff <= here;
         s1_left_ff <= left_pixel_ff;
      end
   end

   // The above-left sample is the row-above sample of the word before
   always_ff @(posedge clock) begin
      if (reset) begin
         above_left_ff <= '0;
      end else if (advance) begin
         above_left_ff <= above;
      end
   end

   brd_plane_select u_plane_select (
      .pos          (s1_pos_ff),
      .here         (RAW_W'(s1_here_ff)),
      .above        (RAW_W'(above)),
      .left         (RAW_W'(s1_left_ff)),
      .above_left   (RAW_W'(above_left_ff)),
      .bit_depth    (bit_depth_ff),
      .mosaic_order (mosaic_order_ff),
      .rsp          (rsp_next)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/brd_line_buffer.sv
// Previous-row line buffer: one sample per column, one port.
// Each access writes the new sample and reads the old one at the same column.
// No dependencies.
`timescale 1ns / 1ps

module brd_line_buffer #(
   parameter int DEPTH  = 4096,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     access,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wr_data,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Read-before-write: the read returns the sample of the row above.
   always_ff @(posedge clock) begin
      if (access) begin
         mem[addr]  <= wr_data;
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/brd_position.sv
// Raster position counters of the demosaic unit.
// Gives the line buffer column and the position flags of each accepted word.
// Depends on brd_pkg.
`timescale 1ns / 1ps

module brd_position #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         frame_start,
   input  logic [brd_pkg::CFG_W-1:0]    image_width,
   input  logic [brd_pkg::CFG_W-1:0]    image_height,
   output logic [$clog2(MAX_WIDTH)-1:0] column,
   output brd_pkg::pos_type             pos
);
   import brd_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int LW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam logic [LW-1:0] MAX_LIM = LW'(MAX_WIDTH);

   logic [AW-1:0]    column_ff, column_in;
   logic [CFG_W-1:0] row_ff, row_in;
   logic [AW-1:0]    x;
   logic [CFG_W-1:0] y;
   logic [LW-1:0]    w_eff, w_last;
   logic [CFG_W-1:0] h_eff, h_last;
   logic             row_end, frame_end;

   // Current position; a frame start puts the word at the origin
   assign x = frame_start ? '0 : column_ff;
   assign y = frame_start ? '0 : row_ff;

   // Effective frame size: zero counts as one, width clamped to the buffer
   always_comb begin
      w_eff = (image_width == '0) ? LW'(1) : LW'(image_width);
      if (w_eff > MAX_LIM) begin
         w_eff = MAX_LIM;
      end
      w_last = w_eff - LW'(1);
      h_eff  = (image_height == '0) ? CFG_W'(1) : image_height;
      h_last = h_eff - CFG_W'(1);
   end

   assign row_end   = LW'(x) >= w_last;
   assign frame_end = row_end && (y >= h_last);

   // Next position
   always_comb begin
      if (row_end) begin
         column_in = '0;
         row_in    = frame_end ? '0 : y + CFG_W'(1);
      end else begin
         column_in = x + AW'(1);
         row_in    = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else if (accept) begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign column     = x;
   assign pos.x_odd  = x[0];
   assign pos.y_odd  = y[0];
   assign pos.x_zero = (x == '0);
   assign pos.y_zero = (y == '0);
   assign pos.last   = frame_end;

endmodule

### rtl/brd_plane_select.sv
// Plane selection of the demosaic unit: picks the anchor of each colour plane,
// scales it to a byte and orders the bytes. Purely combinational.
// Depends on brd_pkg.
`timescale 1ns / 1ps

module brd_plane_select (
   input  brd_pkg::pos_type                pos,
   input  logic [brd_pkg::RAW_W-1:0]       here,
   input  logic [brd_pkg::RAW_W-1:0]       above,
   input  logic [brd_pkg::RAW_W-1:0]       left,
   input  logic [brd_pkg::RAW_W-1:0]       above_left,
   input  logic [brd_pkg::DEPTH_W-1:0]     bit_depth,
   input  logic [brd_pkg::ORDER_W-1:0]     mosaic_order,
   output brd_pkg::rsp_type                rsp
);
   import brd_pkg::*;

   logic             shifted_layout;
   logic [RAW_W-1:0] plane_a, plane_c, plane_g;
   logic [7:0]       byte_a, byte_c;

   // Orders 0 and 1 anchor plane A on even rows; orders 2 and 3 on odd rows
   assign shifted_layout = mosaic_order[1];

   always_comb begin
      if (!shifted_layout) begin
         plane_a = anchor_value(pos, 1'b0, 1'b0, here, above, left, above_left);
         plane_c = anchor_value(pos, 1'b1, 1'b1, here, above, left, above_left);
         plane_g = anchor_value(pos, ~pos.y_odd, pos.y_odd, here, above, left, above_left);
      end else begin
         plane_a = anchor_value(pos, 1'b0, 1'b1, here, above, left, above_left);
         plane_c = anchor_value(pos, 1'b1, 1'b0, here, above, left, above_left);
         plane_g = anchor_value(pos, pos.y_odd, pos.y_odd, here, above, left, above_left);
      end
   end

   assign byte_a = to_byte(plane_a, bit_depth);
   assign byte_c = to_byte(plane_c, bit_depth);

   // Orders 1 and 3 put plane C in the first byte
   always_comb begin
      rsp.first_byte    = mosaic_order[0] ? byte_c : byte_a;
      rsp.third_byte    = mosaic_order[0] ? byte_a : byte_c;
      rsp.green_byte    = to_byte(plane_g, bit_depth);
      rsp.last_of_frame = pos.last;
   end

endmodule

### sim/tb_bayer_replication_demosaic_unit.sv
// Self-checking testbench for the Bayer replication demosaic unit.
// Drives raw words under random bursts and stalls, predicts every colour word.
// Depends on brd_pkg and bayer_replication_demosaic_unit.
`timescale 1ns / 1ps

module tb_bayer_replication_demosaic_unit;
   import brd_pkg::*;

   localparam int LINE_DEPTH = 4096;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_WORDS = 1350;

   // Mosaic orders as held in the order register
   localparam logic [ORDER_W-1:0] ORDER_RGRG = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_BGBG = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_GRGR = 2'd2;
   localparam logic [ORDER_W-1:0] ORDER_GBGB = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   // Predictor copy of the registers and the pixel history
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic [DEPTH_W-1:0] depth_reg;
   logic [ORDER_W-1:0] order_reg;
   logic [RAW_W-1:0] line_store [0:LINE_DEPTH-1];
   bit line_written [0:LINE_DEPTH-1];
   logic [RAW_W-1:0] left_sample;
   logic [RAW_W-1:0] above_left_sample;
   int pixel_col;
   int pixel_row;

   rsp_type expected_pixels [$];
   int error_count = 0;
   int burst_left = 0;
   int words_sent = 0;

   bayer_replication_demosaic_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Value of the plane anchored at column parity pc and row parity pr.
   // Anchors left of column 0 or above row 0 were never written and read as zero.
   function automatic logic [RAW_W-1:0] anchor_sample(input int x, input int y,
         input bit pc, input bit pr, input logic [RAW_W-1:0] here,
         input logic [RAW_W-1:0] above);
      bit back_col;
      bit back_row;
      logic [RAW_W-1:0] v;
      back_col = x[0] != pc;
      back_row = y[0] != pr;
      if ((back_col && x == 0) || (back_row && y == 0)) begin
         v = '0;
      end else if (!back_row) begin
         v = back_col ? left_sample : here;
      end else begin
         v = back_col ? above_left_sample : above;
      end
      return v;
   endfunction

   function automatic logic [7:0] scale_sample(input logic [RAW_W-1:0] v);
      int sh;
      logic [RAW_W-1:0] s;
      sh = (depth_reg > 5'd8) ? int'(depth_reg) - 8 : 0;
      s = v >> sh;
      return s[7:0];
   endfunction

   // Works out the colour word for one accepted raw word and advances the history.
   function automatic rsp_type demosaic_pixel(input req_type word);
      int w;
      int h;
      int x;
      int y;
      logic [RAW_W-1:0] here;
      logic [RAW_W-1:0] above;
      logic [RAW_W-1:0] plane_a;
      logic [RAW_W-1:0] plane_c;
      logic [RAW_W-1:0] plane_g;
      bit row_end;
      bit frame_end;
      rsp_type r;
      here = word.raw_pixel;
      w = (width_reg == 0) ? 1 : int'(width_reg);
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      h = (height_reg == 0) ? 1 : int'(height_reg);
      if (word.frame_start) begin
         pixel_col = 0;
         pixel_row = 0;
      end
      x = pixel_col;
      y = pixel_row;
      above = line_store[x];
      if (order_reg == ORDER_RGRG || order_reg == ORDER_BGBG) begin
         plane_a = anchor_sample(x, y, 1'b0, 1'b0, here, above);
         plane_c = anchor_sample(x, y, 1'b1, 1'b1, here, above);
         plane_g = anchor_sample(x, y, ~y[0], y[0], here, above);
      end else begin
         plane_a = anchor_sample(x, y, 1'b0, 1'b1, here, above);
         plane_c = anchor_sample(x, y, 1'b1, 1'b0, here, above);
         plane_g = anchor_sample(x, y, y[0], y[0], here, above);
      end
      row_end = x >= w - 1;
      frame_end = row_end && y >= h - 1;
      if (order_reg == ORDER_RGRG || order_reg == ORDER_GRGR) begin
         r.first_byte = scale_sample(plane_a);
         r.third_byte = scale_sample(plane_c);
      end else begin
         r.first_byte = scale_sample(plane_c);
         r.third_byte = scale_sample(plane_a);
      end
      r.green_byte = scale_sample(plane_g);
      r.last_of_frame = frame_end;
      line_store[x] = here;
      line_written[x] = 1'b1;
      above_left_sample = above;
      left_sample = here;
      if (row_end) begin
         pixel_col = 0;
         pixel_row = frame_end ? 0 : y + 1;
      end else begin
         pixel_col = x + 1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // Sends one raw word, with a random gap whenever a burst runs out.
   // A row above 0 may only read line entries that have been written, so a word
   // that would read a fresh entry starts a new frame instead.
   task automatic send_pixel(input logic [RAW_W-1:0] raw, input bit fs);
      req_type word;
      bit taken;
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      if (!fs && pixel_row != 0 && !line_written[pixel_col]) fs = 1'b1;
      word.raw_pixel = raw;
      word.frame_start = fs;
      req_valid <= 1'b1;
      req_data <= word;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      expected_pixels.push_back(demosaic_pixel(word));
      burst_left--;
      words_sent++;
   endtask

   // Stops sending and waits until every expected word has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register; valid stays high so that writes can follow back to back.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
         input logic [CFG_W-1:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      case (idx)
         CSR_IMAGE_WIDTH:  width_reg = value;
         CSR_IMAGE_HEIGHT: height_reg = value;
         CSR_BIT_DEPTH:    depth_reg = value[DEPTH_W-1:0];
         CSR_MOSAIC_ORDER: order_reg = value[ORDER_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
         input logic [CFG_W-1:0] depth, input logic [CFG_W-1:0] order);
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
      write_register(CSR_BIT_DEPTH, depth);
      write_register(CSR_MOSAIC_ORDER, order);
      csr_valid <= 1'b0;
   endtask

   // A few words under the reset settings: full width, 8-bit depth, RGRG.
   task automatic test_reset_defaults();
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h00FF, 1'b0);
      send_pixel(16'hFF00, 1'b0);
      wait_for_drain();
   endtask

   // Every mosaic order on a 3x2 frame, each at its own bit depth: 8, 16, 0 and 31.
   task automatic test_orders_and_depths();
      logic [RAW_W-1:0] samples [0:5];
      logic [CFG_W-1:0] depths [0:3];
      samples = '{16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE, 16'hA5A5, 16'h5A5A};
      depths = '{13'd8, 13'd16, 13'd0, 13'd31};
      for (int o = 0; o < 4; o++) begin
         program_frame(13'd3, 13'd2, depths[o], 13'(o));
         for (int i = 0; i < 6; i++) send_pixel(samples[i], i == 0);
         wait_for_drain();
      end
   endtask

   // Registers shrinking in mid-frame, so the position lies past the new row and
   // frame ends; then a zero width, where every word ends a row.
   task automatic test_shrink_and_zero_width();
      program_frame(13'd10, 13'd5, 13'd12, {11'd0, ORDER_BGBG});
      for (int i = 0; i < 25; i++) send_pixel(16'($urandom), i == 0);
      wait_for_drain();
      program_frame(13'd3, 13'd2, 13'd12, {11'd0, ORDER_GBGB});
      for (int i = 0; i < 10; i++) send_pixel(16'($urandom), 1'b0);
      wait_for_drain();
      program_frame(13'd0, 13'd3, 13'd9, {11'd0, ORDER_GRGR});
      for (int i = 0; i < 5; i++) send_pixel(16'($urandom), i == 0);
      wait_for_drain();
   endtask

   // Width beyond the line store acts as full width, so no row ends early;
   // a zero height acts as one row.
   task automatic test_maximum_width();
      program_frame(13'h1FFF, 13'd0, 13'd10, {11'd0, ORDER_RGRG});
      for (int i = 0; i < 48; i++) send_pixel(16'($urandom), i == 0);
      wait_for_drain();
   endtask

   // Random frame settings, mostly small frames, run in phases of random length.
   task automatic test_random_frames();
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] h;
      logic [CFG_W-1:0] depth;
      logic [CFG_W-1:0] order;
      logic [RAW_W-1:0] raw;
      int count;
      int pick;
      bit fs;
      while (words_sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) w = 13'($urandom_range(1, 16));
         else if (pick < 9) w = 13'($urandom_range(17, 80));
         else w = 13'($urandom_range(0, 2));
         h = 13'($urandom_range(0, 6));
         depth = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 31))
                                             : 13'($urandom_range(8, 16));
         order = 13'($urandom_range(0, 3));
         // Junk in the unused upper bits must be ignored
         if ($urandom_range(0, 3) == 0) depth[CFG_W-1:DEPTH_W] = 8'($urandom);
         if ($urandom_range(0, 3) == 0) order[CFG_W-1:ORDER_W] = 11'($urandom);
         program_frame(w, h, depth, order);
         count = $urandom_range(16, 70);
         for (int i = 0; i < count; i++) begin
            if (i == 0) fs = $urandom_range(0, 4) != 0;
            else fs = $urandom_range(0, 59) == 0;
            pick = $urandom_range(0, 15);
            raw = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
            send_pixel(raw, fs);
         end
         wait_for_drain();
      end
   endtask

   // Checks each colour word taken from the result side against the oldest prediction.
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("result word with nothing expected", 32'(rsp_data), 32'd0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.first_byte !== want.first_byte)
               report_mismatch("first_byte", 32'(rsp_data.first_byte), 32'(want.first_byte));
            if (rsp_data.green_byte !== want.green_byte)
               report_mismatch("green_byte", 32'(rsp_data.green_byte), 32'(want.green_byte));
            if (rsp_data.third_byte !== want.third_byte)
               report_mismatch("third_byte", 32'(rsp_data.third_byte), 32'(want.third_byte));
            if (rsp_data.last_of_frame !== want.last_of_frame)
               report_mismatch("last_of_frame", 32'(rsp_data.last_of_frame),
                               32'(want.last_of_frame));
         end
      end
   end

   // Result-side back-pressure: spans of no stall, random, periodic and long stalls.
   initial begin
      int mode;
      int span;
      int period;
      int count;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 150);
         period = $urandom_range(2, 9);
         count = 0;
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= $urandom_range(0, 99) < 35;
               2: rsp_stall <= (count % period) < (period / 2);
               default: rsp_stall <= $urandom_range(0, 99) < 85;
            endcase
            count++;
         end
      end
   end

   // Ends the run when no word moves on any channel for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb_bayer_replication_demosaic_unit: FAIL");
      $finish;
   end

   initial begin
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      depth_reg = RESET_DEPTH;
      order_reg = RESET_ORDER;
      left_sample = '0;
      above_left_sample = '0;
      pixel_col = 0;
      pixel_row = 0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_store[i] = '0;
         line_written[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_orders_and_depths();
      test_shrink_and_zero_width();
      test_maximum_width();
      test_random_frames();
      wait_for_drain();
      if (error_count == 0) begin
         $display("tb_bayer_replication_demosaic_unit: PASS");
      end else begin
         $display("tb_bayer_replication_demosaic_unit: FAIL");
      end
      $finish;
   end

endmodule

### bayer_replication_demosaic_unit.f
rtl/brd_pkg.sv
rtl/brd_line_buffer.sv
rtl/brd_position.sv
rtl/brd_plane_select.sv
rtl/bayer_replication_demosaic_unit.sv
sim/tb_bayer_replication_demosaic_unit.sv
